// ----- rtl/dal_pkg.sv -----
// shared constants, word types and helper functions for the delta arm link angle block
package dal_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_WIDTH   = 32;
	localparam int CORDIC_STAGES = 24;

	localparam int WORK_W     = 64;
	localparam int ROT_FRAC   = 61 - COORD_WIDTH;
	localparam int WORK_FRAC  = 60;
	localparam int ANGLE_FRAC = ANGLE_WIDTH - 4;
	localparam int ANG_SH     = WORK_FRAC - ANGLE_FRAC;
	localparam int NRM_TOP    = 30;
	localparam int NRM_W      = NRM_TOP + 3;
	localparam int CRD_TOP    = 58;
	localparam int SQRT_STEPS = WORK_W / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int LEN_W      = $clog2(WORK_W + 1);
	localparam int SH_W       = $clog2(WORK_W);

	localparam logic [1:0] ARM_ROT120 = 2'd1;
	localparam logic [1:0] ARM_ROT240 = 2'd3;

	localparam logic signed [WORK_W-1:0] PI_Q60         = 64'sh3243F6A8885A308D;
	localparam logic signed [WORK_W-1:0] HALF_PI_Q60    = 64'sh1921FB54442D1847;
	localparam logic signed [WORK_W-1:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
	localparam logic signed [WORK_W-1:0] SQRT3_HALF_Q52 = 64'sh000DDB3D742C2655;
	localparam logic signed [WORK_W-1:0] SQ_ROT =
		(SQRT3_HALF_Q52 + (64'sd1 <<< (52 - ROT_FRAC - 1))) >>> (52 - ROT_FRAC);
	localparam logic signed [WORK_W-1:0] ANG_RND = 64'sd1 <<< (ANG_SH - 1);

	typedef struct packed {
		logic [1:0]                    arm_select;
		logic signed [COORD_WIDTH-1:0] elbow_x;
		logic signed [COORD_WIDTH-1:0] elbow_y;
		logic signed [COORD_WIDTH-1:0] elbow_z;
		logic signed [COORD_WIDTH-1:0] effector_x;
		logic signed [COORD_WIDTH-1:0] effector_y;
		logic signed [COORD_WIDTH-1:0] effector_z;
	} item_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] angle_a;
		logic signed [ANGLE_WIDTH-1:0] angle_b;
		logic                          a_vertical;
		logic                          b_degenerate;
	} result_t;

	typedef struct packed {
		logic signed [WORK_W-1:0] dx;
		logic signed [WORK_W-1:0] dz;
		logic signed [WORK_W-1:0] ey;
	} rot_t;

	typedef struct packed {
		logic signed [WORK_W-1:0] dx;
		logic signed [WORK_W-1:0] dz;
		logic signed [WORK_W-1:0] ey;
		logic signed [NRM_W-1:0]  ny;
		logic                     vert;
		logic                     degen;
	} side_t;

	typedef struct packed {
		logic vert;
		logic degen;
		logic dx_neg;
		logic dz_neg;
	} flag_t;

	function automatic logic [WORK_W-1:0] udiv_pow2(int unsigned e, int unsigned d);
		logic [WORK_W-1:0] num;
		logic [WORK_W-1:0] q;
		logic [WORK_W-1:0] r;
		num = {{(WORK_W-1){1'b0}}, 1'b1} << e;
		q = '0;
		r = '0;
		for (int b = WORK_W - 1; b >= 0; b--) begin
			r = {r[WORK_W-2:0], num[b]};
			if (r >= WORK_W'(d)) begin
				r = r - WORK_W'(d);
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [WORK_W-1:0] atan_q60(int unsigned i);
		logic signed [WORK_W-1:0] sum;
		logic [WORK_W-1:0]        term;
		int unsigned              sh;
		sum = '0;
		if (i == 0) begin
			sum = QUARTER_PI_Q60;
		end else begin
			for (int unsigned k = 0; k < 31; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= WORK_FRAC) begin
					term = udiv_pow2(WORK_FRAC - sh, 2 * k + 1);
					if (k[0])
						sum = sum - $signed(term);
					else
						sum = sum + $signed(term);
				end
			end
		end
		return sum;
	endfunction

	function automatic logic [LEN_W-1:0] bit_len(logic [WORK_W-1:0] m);
		logic [LEN_W-1:0] len;
		len = '0;
		for (int i = 0; i < WORK_W; i++)
			if (m[i])
				len = LEN_W'(i + 1);
		return len;
	endfunction

	function automatic logic signed [WORK_W-1:0] scale_pow2(logic signed [WORK_W-1:0] v,
			logic left, logic [SH_W-1:0] sh);
		return left ? (v <<< sh) : (v >>> sh);
	endfunction

	function automatic logic signed [ANGLE_WIDTH-1:0] to_angle(logic signed [WORK_W-1:0] z);
		logic signed [WORK_W-1:0] t;
		t = z + ANG_RND;
		return $signed(t[ANG_SH +: ANGLE_WIDTH]);
	endfunction

endpackage

// ----- rtl/dal_rotate.sv -----
// front end: coordinate differences and rotation about z for the selected arm
module dal_rotate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  dal_pkg::item_t in_item,
	output logic           out_valid,
	output dal_pkg::rot_t  out_rot
);
	import dal_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic [1:0] arm_s1, arm_s2;
	logic signed [COORD_WIDTH:0] ddx_s1, ddy_s1, dzd_s1, ddx_s2, dzd_s2;
	logic signed [COORD_WIDTH-1:0] ex_s1, eyi_s1, eyi_s2;
	logic signed [WORK_W-1:0] pdy_s2, pex_s2;
	rot_t rot_s3;
	logic signed [WORK_W-1:0] hdx_c, hey_c, dx_c, ey_c;

	always_comb begin
		hdx_c = WORK_W'(ddx_s2) <<< (ROT_FRAC - 1);
		hey_c = WORK_W'(eyi_s2) <<< (ROT_FRAC - 1);
		case (arm_s2)
			ARM_ROT120: begin
				dx_c = -hdx_c + pdy_s2;
				ey_c = -pex_s2 - hey_c;
			end
			ARM_ROT240: begin
				dx_c = -hdx_c - pdy_s2;
				ey_c = pex_s2 - hey_c;
			end
			default: begin
				dx_c = WORK_W'(ddx_s2) <<< ROT_FRAC;
				ey_c = WORK_W'(eyi_s2) <<< ROT_FRAC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arm_s1 <= in_item.arm_select;
			ddx_s1 <= (COORD_WIDTH+1)'(in_item.elbow_x) - (COORD_WIDTH+1)'(in_item.effector_x);
			ddy_s1 <= (COORD_WIDTH+1)'(in_item.elbow_y) - (COORD_WIDTH+1)'(in_item.effector_y);
			dzd_s1 <= (COORD_WIDTH+1)'(in_item.effector_z) - (COORD_WIDTH+1)'(in_item.elbow_z);
			ex_s1  <= in_item.effector_x;
			eyi_s1 <= in_item.effector_y;
			arm_s2 <= arm_s1;
			pdy_s2 <= SQ_ROT * WORK_W'(ddy_s1);
			pex_s2 <= SQ_ROT * WORK_W'(ex_s1);
			ddx_s2 <= ddx_s1;
			dzd_s2 <= dzd_s1;
			eyi_s2 <= eyi_s1;
			rot_s3.dx <= dx_c;
			rot_s3.ey <= ey_c;
			rot_s3.dz <= WORK_W'(dzd_s2) <<< ROT_FRAC;
		end
	end

	assign out_valid = v_s3;
	assign out_rot   = rot_s3;

endmodule

// ----- rtl/dal_prep.sv -----
// normalizes the rotated differences and forms the sum of squares for the root
module dal_prep (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  dal_pkg::rot_t             in_rot,
	output logic                      out_valid,
	output logic [dal_pkg::WORK_W-1:0] sq_sum,
	output dal_pkg::side_t            out_side
);
	import dal_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rot_t r_s1, r_s2, r_s3, r_s4, r_s5;
	logic [WORK_W-1:0] mdx_s1, mdz_s1, mey_s1, m_s2;
	logic vert_s1, vert_s2, vert_s3, vert_s4, vert_s5;
	logic degen_s1, degen_s2, degen_s3, degen_s4, degen_s5;
	logic left_s3;
	logic [SH_W-1:0] sh_s3;
	logic signed [NRM_W-1:0] nx_s4, nz_s4, ny_s4, ny_s5;
	logic [WORK_W-1:0] sqx_s5, sqz_s5, sum_s6;
	side_t side_s6;
	logic [WORK_W-1:0] mxz_c;
	logic [LEN_W-1:0] len_c;

	always_comb begin
		mxz_c = (mdx_s1 > mdz_s1) ? mdx_s1 : mdz_s1;
		len_c = bit_len(m_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= in_rot;
			mdx_s1   <= in_rot.dx[WORK_W-1] ? $unsigned(-in_rot.dx) : $unsigned(in_rot.dx);
			mdz_s1   <= in_rot.dz[WORK_W-1] ? $unsigned(-in_rot.dz) : $unsigned(in_rot.dz);
			mey_s1   <= in_rot.ey[WORK_W-1] ? $unsigned(-in_rot.ey) : $unsigned(in_rot.ey);
			vert_s1  <= in_rot.dx == '0;
			degen_s1 <= (in_rot.dx == '0) && (in_rot.dz == '0);

			r_s2     <= r_s1;
			m_s2     <= (mxz_c > mey_s1) ? mxz_c : mey_s1;
			vert_s2  <= vert_s1;
			degen_s2 <= degen_s1;

			r_s3     <= r_s2;
			left_s3  <= len_c <= LEN_W'(NRM_TOP + 1);
			sh_s3    <= (len_c <= LEN_W'(NRM_TOP + 1)) ?
				SH_W'(LEN_W'(NRM_TOP + 1) - len_c) : SH_W'(len_c - LEN_W'(NRM_TOP + 1));
			vert_s3  <= vert_s2;
			degen_s3 <= degen_s2;

			r_s4     <= r_s3;
			nx_s4    <= NRM_W'(scale_pow2(r_s3.dx, left_s3, sh_s3));
			nz_s4    <= NRM_W'(scale_pow2(r_s3.dz, left_s3, sh_s3));
			ny_s4    <= NRM_W'(scale_pow2(r_s3.ey, left_s3, sh_s3));
			vert_s4  <= vert_s3;
			degen_s4 <= degen_s3;

			r_s5     <= r_s4;
			sqx_s5   <= WORK_W'(nx_s4) * WORK_W'(nx_s4);
			sqz_s5   <= WORK_W'(nz_s4) * WORK_W'(nz_s4);
			ny_s5    <= ny_s4;
			vert_s5  <= vert_s4;
			degen_s5 <= degen_s4;

			sum_s6        <= sqx_s5 + sqz_s5;
			side_s6.dx    <= r_s5.dx;
			side_s6.dz    <= r_s5.dz;
			side_s6.ey    <= r_s5.ey;
			side_s6.ny    <= ny_s5;
			side_s6.vert  <= vert_s5;
			side_s6.degen <= degen_s5;
		end
	end

	assign out_valid = v_s6;
	assign sq_sum    = sum_s6;
	assign out_side  = side_s6;

endmodule

// ----- rtl/dal_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module dal_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [dal_pkg::WORK_W-1:0] radicand,
	input  dal_pkg::side_t             in_side,
	output logic                       out_valid,
	output logic [dal_pkg::ROOT_W-1:0] root,
	output dal_pkg::side_t             out_side
);
	import dal_pkg::*;

	logic [WORK_W-1:0] rem_s [SQRT_STEPS];
	logic [WORK_W-1:0] res_s [SQRT_STEPS];
	logic              v_s   [SQRT_STEPS];
	side_t             sd_s  [SQRT_STEPS];

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [WORK_W-1:0] BIT = {{(WORK_W-1){1'b0}}, 1'b1} << (WORK_W - 2 - 2 * i);
		logic [WORK_W-1:0] rem_c, res_c, trial_c;
		logic              v_c;
		side_t             sd_c;

		if (i == 0) begin : g_first
			assign rem_c = radicand;
			assign res_c = '0;
			assign v_c   = in_valid;
			assign sd_c  = in_side;
		end else begin : g_next
			assign rem_c = rem_s[i-1];
			assign res_c = res_s[i-1];
			assign v_c   = v_s[i-1];
			assign sd_c  = sd_s[i-1];
		end

		assign trial_c = res_c + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (en)
				v_s[i] <= v_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i] <= sd_c;
				if (rem_c >= trial_c) begin
					rem_s[i] <= rem_c - trial_c;
					res_s[i] <= (res_c >> 1) + BIT;
				end else begin
					rem_s[i] <= rem_c;
					res_s[i] <= res_c >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS-1];
	assign root      = res_s[SQRT_STEPS-1][ROOT_W-1:0];
	assign out_side  = sd_s[SQRT_STEPS-1];

endmodule

// ----- rtl/dal_cordic.sv -----
// vectoring cordic arctangent with operand normalization, one rotation per stage
module dal_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [dal_pkg::WORK_W-1:0] num,
	input  logic signed [dal_pkg::WORK_W-1:0] den,
	input  dal_pkg::flag_t                    in_flag,
	output logic                              out_valid,
	output logic signed [dal_pkg::WORK_W-1:0] z,
	output dal_pkg::flag_t                    out_flag
);
	import dal_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [WORK_W-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic [WORK_W-1:0] m_s2;
	logic left_s3, zero_s3, zero_s4;
	logic [SH_W-1:0] sh_s3;
	flag_t f_s1, f_s2, f_s3, f_s4;
	logic [WORK_W-1:0] my_c, m_c;
	logic [LEN_W-1:0] len_c;

	logic signed [WORK_W-1:0] cx_s [CORDIC_STAGES];
	logic signed [WORK_W-1:0] cy_s [CORDIC_STAGES];
	logic signed [WORK_W-1:0] cz_s [CORDIC_STAGES];
	logic                     cv_s [CORDIC_STAGES];
	logic                     cn_s [CORDIC_STAGES];
	flag_t                    cf_s [CORDIC_STAGES];

	always_comb begin
		my_c  = y_s1[WORK_W-1] ? $unsigned(-y_s1) : $unsigned(y_s1);
		m_c   = ($unsigned(x_s1) > my_c) ? $unsigned(x_s1) : my_c;
		len_c = bit_len(m_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= den[WORK_W-1] ? -den : den;
			y_s1    <= den[WORK_W-1] ? -num : num;
			f_s1    <= in_flag;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			m_s2    <= m_c;
			f_s2    <= f_s1;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			left_s3 <= len_c <= LEN_W'(CRD_TOP + 1);
			sh_s3   <= (len_c <= LEN_W'(CRD_TOP + 1)) ?
				SH_W'(LEN_W'(CRD_TOP + 1) - len_c) : SH_W'(len_c - LEN_W'(CRD_TOP + 1));
			zero_s3 <= m_s2 == '0;
			f_s3    <= f_s2;
			x_s4    <= scale_pow2(x_s3, left_s3, sh_s3);
			y_s4    <= scale_pow2(y_s3, left_s3, sh_s3);
			zero_s4 <= zero_s3;
			f_s4    <= f_s3;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [WORK_W-1:0] STEP = atan_q60(i);
		logic signed [WORK_W-1:0] x_c, y_c, z_c;
		logic                     v_c, n_c;
		flag_t                    f_c;

		if (i == 0) begin : g_first
			assign x_c = x_s4;
			assign y_c = y_s4;
			assign z_c = '0;
			assign v_c = v_s4;
			assign n_c = zero_s4;
			assign f_c = f_s4;
		end else begin : g_next
			assign x_c = cx_s[i-1];
			assign y_c = cy_s[i-1];
			assign z_c = cz_s[i-1];
			assign v_c = cv_s[i-1];
			assign n_c = cn_s[i-1];
			assign f_c = cf_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[i] <= 1'b0;
			else if (en)
				cv_s[i] <= v_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cn_s[i] <= n_c;
				cf_s[i] <= f_c;
				if (y_c[WORK_W-1]) begin
					cx_s[i] <= x_c - (y_c >>> i);
					cy_s[i] <= y_c + (x_c >>> i);
					cz_s[i] <= z_c - STEP;
				end else begin
					cx_s[i] <= x_c + (y_c >>> i);
					cy_s[i] <= y_c - (x_c >>> i);
					cz_s[i] <= z_c + STEP;
				end
			end
		end
	end

	assign out_valid = cv_s[CORDIC_STAGES-1];
	assign z         = cn_s[CORDIC_STAGES-1] ? '0 : cz_s[CORDIC_STAGES-1];
	assign out_flag  = cf_s[CORDIC_STAGES-1];

endmodule

// ----- rtl/delta_arm_link_angles.sv -----
// delta arm link angles: every stage of the 70-stage pipeline holds one word
// throughput is one word per cycle while the output buffer is not full
// a two-word output buffer lets the pipeline keep moving while a result waits
// input ready is low only while that buffer is full
// arst_n clears all valid bits and the buffer count; data registers are not reset
module delta_arm_link_angles (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  dal_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output dal_pkg::result_t result
);
	import dal_pkg::*;

	localparam logic [1:0] BUF_FULL = 2'd2;
	localparam logic signed [ANGLE_WIDTH-1:0] ANG_HALF_PI  = to_angle(HALF_PI_Q60);
	localparam logic signed [ANGLE_WIDTH-1:0] ANG_3HALF_PI = to_angle(HALF_PI_Q60 + PI_Q60);

	logic pipe_en;
	logic rot_valid, prep_valid, sqrt_valid, ca_valid, cb_valid;
	rot_t rot;
	logic [WORK_W-1:0] sq_sum;
	side_t prep_side, sqrt_side;
	logic [ROOT_W-1:0] root;
	flag_t flag_c, fa, fb;
	logic signed [WORK_W-1:0] b_num_c, b_den_c, za, zb;

	logic v_f1, vert_f1, degen_f1;
	logic signed [WORK_W-1:0] a_f1, b_f1;

	logic [1:0] cnt_q;
	result_t e0_q, e1_q, push_word;
	logic push, pop;

	assign pipe_en    = cnt_q != BUF_FULL;
	assign item_ready = pipe_en;

	dal_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (item_valid),
		.in_item  (item),
		.out_valid(rot_valid),
		.out_rot  (rot)
	);

	dal_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (rot_valid),
		.in_rot   (rot),
		.out_valid(prep_valid),
		.sq_sum   (sq_sum),
		.out_side (prep_side)
	);

	dal_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (prep_valid),
		.radicand (sq_sum),
		.in_side  (prep_side),
		.out_valid(sqrt_valid),
		.root     (root),
		.out_side (sqrt_side)
	);

	always_comb begin
		flag_c.vert   = sqrt_side.vert;
		flag_c.degen  = sqrt_side.degen;
		flag_c.dx_neg = sqrt_side.dx[WORK_W-1];
		flag_c.dz_neg = sqrt_side.dz[WORK_W-1];
		if (sqrt_side.vert) begin
			b_num_c = sqrt_side.ey;
			b_den_c = sqrt_side.dz;
		end else begin
			b_num_c = WORK_W'(sqrt_side.ny);
			b_den_c = WORK_W'($signed({1'b0, root}));
		end
	end

	dal_cordic u_cordic_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (sqrt_valid),
		.num      (sqrt_side.dz),
		.den      (sqrt_side.dx),
		.in_flag  (flag_c),
		.out_valid(ca_valid),
		.z        (za),
		.out_flag (fa)
	);

	dal_cordic u_cordic_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (sqrt_valid),
		.num      (b_num_c),
		.den      (b_den_c),
		.in_flag  (flag_c),
		.out_valid(cb_valid),
		.z        (zb),
		.out_flag (fb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_f1 <= 1'b0;
		else if (pipe_en)
			v_f1 <= ca_valid && cb_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (fa.vert)
				a_f1 <= fa.dz_neg ? HALF_PI_Q60 + PI_Q60 : HALF_PI_Q60;
			else
				a_f1 <= fa.dx_neg ? za + PI_Q60 : za;
			b_f1     <= fb.degen ? '0 : zb;
			vert_f1  <= fa.vert;
			degen_f1 <= fb.degen;
		end
	end

	always_comb begin
		push_word.angle_a      = to_angle(a_f1);
		push_word.angle_b      = to_angle(b_f1);
		push_word.a_vertical   = vert_f1;
		push_word.b_degenerate = degen_f1;
	end

	assign result_valid = cnt_q != 2'd0;
	assign result       = e0_q;
	assign pop          = result_valid && result_ready;
	assign push         = pipe_en && v_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			e0_q <= (cnt_q == BUF_FULL) ? e1_q : push_word;
		end else if (push) begin
			if (cnt_q == 2'd0)
				e0_q <= push_word;
			else
				e1_q <= push_word;
		end
	end

	a_degen_vert: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.b_degenerate |-> result.a_vertical)
		else $error("degenerate word without vertical flag");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.b_degenerate |-> result.angle_b == '0)
		else $error("degenerate word with nonzero angle_b");

	a_vert_angle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.a_vertical |->
			(result.angle_a == ANG_HALF_PI) || (result.angle_a == ANG_3HALF_PI))
		else $error("vertical word with unexpected angle_a");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(v_f1))
		else $error("pipeline moved while stalled");

endmodule
